/* design/hsis_pkg.sv */
// Package for the hashed set insert/search block.
// Holds field widths, operation and status codes, default sizes and the item type.
// No dependencies.
package hsis_pkg;

    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam int BUCKETS_DEF = 10;
    localparam int WAYS_DEF    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } hsis_item_t;

endpackage

/* design/hsis_front.sv */
// Front end of the hashed set: accepts request transactions and computes the bucket.
// Depends on hsis_pkg.
module hsis_front
    import hsis_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int BKT_W   = $clog2(BUCKETS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic             func,
    input  logic [KEY_W-1:0] key_value,
    output logic             push,
    input  logic             push_ready,
    output hsis_item_t       push_item,
    output logic [BKT_W-1:0] push_bucket
);

    // Exact quotient by multiplying with a rounded-up reciprocal.
    localparam int          SHIFT      = KEY_W + $clog2(BUCKETS);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0]      RECIP     = RECIP_WIDE[31:0];
    localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);
    localparam int               PROD_W    = KEY_W + 32;

    logic              valid_reg;
    hsis_item_t        item_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              accept;
    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  rem;

    assign req_stall = valid_reg && !push_ready;
    assign accept    = req_valid && !req_stall;
    assign push      = valid_reg && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.func <= func;
            item_reg.key  <= key_value;
            prod_reg      <= PROD_W'(key_value) * PROD_W'(RECIP);
        end
    end

    always_comb
    begin
        quot = KEY_W'(prod_reg >> SHIFT);
        rem  = item_reg.key - quot * BUCKETS_K;
    end

    assign push_item   = item_reg;
    assign push_bucket = BKT_W'(rem);

endmodule

/* design/hsis_queue.sv */
// Short FIFO between the front end and the back end of the hashed set.
// Depends on hsis_pkg.
module hsis_queue
    import hsis_pkg::*;
#(
    parameter int DATA_W = KEY_W + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/hsis_back.sv */
// Back end of the hashed set: bucket store, fill counts, lookup and response register.
// Depends on hsis_pkg.
module hsis_back
    import hsis_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF,
    parameter int BKT_W   = $clog2(BUCKETS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_pop,
    input  hsis_item_t          item,
    input  logic [BKT_W-1:0]    item_bucket,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot
);

    localparam int   ROW_W  = WAYS * KEY_W;
    localparam int   FILL_W = $clog2(WAYS + 1);
    localparam int   WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic [ROW_W-1:0]  mem [BUCKETS];
    logic [FILL_W-1:0] fill_reg [BUCKETS];

    logic                state_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [FILL_W-1:0]   cur_fill_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                func_reg;
    logic [BKT_W-1:0]    bucket_reg;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic                hit;
    logic                full;
    logic                wr_en;
    logic [WAY_W-1:0]    wr_way;
    logic [ROW_W-1:0]    row_next;
    logic [STATUS_W-1:0] status_next;

    assign item_pop = (state_reg == S_IDLE) && item_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((FILL_W'(w) < cur_fill_reg) && (row_reg[w*KEY_W +: KEY_W] == key_reg))
            begin
                hit = 1'b1;
            end
        end
        full     = cur_fill_reg >= FILL_W'(WAYS);
        wr_way   = cur_fill_reg[WAY_W-1:0];
        wr_en    = (state_reg == S_LOOK) && (func_reg == FUNC_INSERT) && !full;
        row_next = row_reg;
        row_next[wr_way*KEY_W +: KEY_W] = key_reg;
        if (func_reg == FUNC_INSERT)
        begin
            status_next = full ? ST_FULL : ST_ADDED;
        end
        else
        begin
            status_next = hit ? ST_FOUND : ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_pop)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_LOOK)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fill_reg[bucket_reg] <= cur_fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            row_reg      <= mem[item_bucket];
            cur_fill_reg <= fill_reg[item_bucket];
            key_reg      <= item.key;
            func_reg     <= item.func;
            bucket_reg   <= item_bucket;
        end
        if (wr_en)
        begin
            mem[bucket_reg] <= row_next;
        end
        if (state_reg == S_LOOK)
        begin
            status_reg <= status_next;
            slot_reg   <= SLOT_W'(bucket_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

endmodule

/* design/hashed_set_insert_search.sv */
// Top level of the hashed set with insert and search.
// Depends on hsis_pkg, hsis_front, hsis_queue and hsis_back.
//
// Usage:
// The request channel (req_valid, req_stall) carries one transaction per operation:
// func selects insert or search and key_value is the 31-bit key. The response channel
// (rsp_valid, rsp_stall) returns exactly one transaction per request, in order, with
// status (added, found, not found, bucket full) and slot, the low four bits of the
// bucket index, key modulo BUCKETS.
// The front end registers the key and a reciprocal product, derives the bucket index
// and pushes into a two-entry queue. The back end reads the bucket row and its fill
// count into registers, then compares all ways in parallel and writes the appended key
// back on an insert that finds room.
// A request passes the front register, the queue, the back end's row registers and the
// response register on its way to rsp_valid. The back end takes no new transaction until
// it has finished the read then write-back sequence on the single-port bucket store.
// Reset clears all fill counts and empties the front stage, the queue and the response
// register; no clearing pass is needed, so requests are taken right after reset.
// When the receiver holds rsp_stall, the response stays registered, the back end stops
// popping, the queue fills and req_stall then rises.
module hashed_set_insert_search
    import hsis_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                func,
    input  logic [KEY_W-1:0]    key_value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int ITEM_W = $bits(hsis_item_t);
    localparam int DATA_W = ITEM_W + BKT_W;

    logic              push;
    logic              push_ready;
    hsis_item_t        push_item;
    logic [BKT_W-1:0]  push_bucket;
    logic              pop;
    logic              pop_valid;
    logic [DATA_W-1:0] pop_data;
    hsis_item_t        pop_item;
    logic [BKT_W-1:0]  pop_bucket;

    hsis_front #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .key_value   (key_value),
        .push        (push),
        .push_ready  (push_ready),
        .push_item   (push_item),
        .push_bucket (push_bucket)
    );

    hsis_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  ({push_item, push_bucket}),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    assign pop_item   = pop_data[DATA_W-1:BKT_W];
    assign pop_bucket = pop_data[BKT_W-1:0];

    hsis_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BKT_W   (BKT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pop_valid),
        .item_pop    (pop),
        .item        (pop_item),
        .item_bucket (pop_bucket),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .slot        (slot)
    );

endmodule
